// File: hw/rtl/bm3_pkg.sv
// Shared constants, types and the reciprocal table of the 3x3 box mean filter.
// Depends on nothing; the core and its testbench take names from here.
package bm3_pkg;

	// Frame geometry and sample format.
	localparam int MAX_WIDTH  = 1024;
	localparam int PIXEL_BITS = 16;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int FW_W       = 11;
	localparam int WID_W      = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
	localparam int MEAN_W     = 16;
	localparam int CNT_W      = 4;
	localparam int SUM_W      = PIXEL_BITS + CNT_W;
	localparam int LINE_W     = 2 * PIXEL_BITS;

	// The reciprocal table below is exact for sums below 2**SUM_W and counts up to 9.
	localparam int RECIP_SHIFT = SUM_W + CNT_W;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = RECIP_W + SUM_W;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = FW_W'(640);

	// Register indexes of the configuration port.
	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_PARITY_MODE = 1'b1;

	// Parity selection codes; the unused code selects all neighbours.
	localparam logic [1:0] PAR_ALL  = 2'd0;
	localparam logic [1:0] PAR_EVEN = 2'd1;
	localparam logic [1:0] PAR_ODD  = 2'd2;

	// Kinds of input request.
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// Partial sum and count of qualifying neighbours.
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sum;
	} acc_t;

	// ceil(2**RECIP_SHIFT / d) for d in 1..9; a count of zero gives a zero mean.
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
		logic [RECIP_W-1:0] r;
		unique case (d)
			4'd1:    r = RECIP_W'(16777216);
			4'd2:    r = RECIP_W'(8388608);
			4'd3:    r = RECIP_W'(5592406);
			4'd4:    r = RECIP_W'(4194304);
			4'd5:    r = RECIP_W'(3355444);
			4'd6:    r = RECIP_W'(2796203);
			4'd7:    r = RECIP_W'(2396746);
			4'd8:    r = RECIP_W'(2097152);
			4'd9:    r = RECIP_W'(1864136);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/bm3_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; the filter core uses it as its two-row line buffer.
module bm3_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/box_mean_3x3_filter_core.sv
// Top level of the 3x3 box mean filter: sequencer, window registers, divider.
// Depends on bm3_pkg and on bm3_ram, which holds the two previous rows.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  -------------------------------------------
//  s_*       in         s_tvalid / s_tready  s_tdata = pixel_value, s_tuser = kind
//  m_*       out        m_tvalid / m_tready  m_tdata = mean_value, neighbour_count;
//                                            m_tlast = frame_end
//  cfg_*     in         cfg_we (no wait)     cfg_index selects, cfg_data holds value
//
// A pixel request passes through S_PRD and then S_EMIT once for each result it yields;
// a flush request passes through S_F0, S_F1, S_F2 and S_EMIT; an ignored flush stays in S_IDLE.
// The sequence is set by the single read port of the line buffer (one registered read
// per column, three columns for a flush) and by the one shared reciprocal multiplier
// that turns one result a cycle into the output register while that register is free.
// A result waiting in the output register does not stop the next request from being
// taken; only the next result waits for it. A register write holds off input requests
// in its cycle. Reset clears the sequencer, the counters, the window and the
// configuration; the line buffer needs no clearing.
module box_mean_3x3_filter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration write port.
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [bm3_pkg::FW_W-1:0]   cfg_data,
	// Input stream.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [15:0]                s_tdata,   // [15:0] pixel_value
	input  logic                       s_tuser,   // [0] kind
	// Output stream.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [23:0]                m_tdata,   // [15:0] mean_value, [19:16] neighbour_count
	output logic                       m_tlast
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRD,
		S_F0,
		S_F1,
		S_F2,
		S_EMIT
	} state_t;

	localparam int PB    = bm3_pkg::PIXEL_BITS;
	localparam int CW    = bm3_pkg::COL_W;
	localparam int WW    = bm3_pkg::WID_W;
	localparam int LW    = bm3_pkg::LINE_W;
	localparam int SW    = bm3_pkg::SUM_W;
	localparam int NW    = bm3_pkg::CNT_W;
	localparam int MW    = bm3_pkg::MEAN_W;
	localparam int PW    = bm3_pkg::PROD_W;

	// Configuration and frame position.
	logic [bm3_pkg::FW_W-1:0] frame_width_q;
	logic [1:0]               parity_q;
	logic [CW-1:0]            col_q;
	logic [1:0]               rows_q;
	logic [CW-1:0]            flush_q;

	// Sequencer and the request being worked on.
	state_t                   state_q;
	logic [PB-1:0]            pix_q;
	logic [CW-1:0]            addr_q;
	logic                     top_ok_q;
	logic                     has1_q;
	logic                     has2_q;
	logic                     col0_ok_q;
	logic                     col1_ok_q;
	logic                     ok2_q;
	logic                     last_q;

	// Window: entries 0..2 are the column before last (top, middle, bottom),
	// entries 3..5 the last column.
	logic [PB-1:0]            win_q [6];

	// Pending results.
	bm3_pkg::acc_t            res_a_q;
	bm3_pkg::acc_t            res_b_q;
	logic                     end_a_q;
	logic                     pend_b_q;

	// Output register.
	logic                     m_valid_q;
	logic [MW-1:0]            m_mean_q;
	logic [NW-1:0]            m_cnt_q;
	logic                     m_last_q;

	// Line buffer port.
	logic                     ram_we;
	logic                     ram_re;
	logic [CW-1:0]            ram_raddr;
	logic [LW-1:0]            ram_rdata;
	logic [PB-1:0]            rd_older;
	logic [PB-1:0]            rd_newer;

	// Request decode.
	logic                     accept;
	logic [WW-1:0]            eff_w;
	logic                     restart;
	logic [CW-1:0]            pix_c;
	logic [1:0]               pix_rows;
	logic                     pix_last;
	logic                     flush_ok;
	logic [CW-1:0]            fl_k;
	logic                     fl_ok0;
	logic                     fl_ok2;
	logic                     fl_last;

	// Column sums and division.
	bm3_pkg::acc_t            acc_cur;
	bm3_pkg::acc_t            acc_w1;
	bm3_pkg::acc_t            acc_w0;
	bm3_pkg::acc_t            acc_fl;
	bm3_pkg::acc_t            sum1;
	bm3_pkg::acc_t            sum2;
	logic [bm3_pkg::PROD_W-1:0] prod;
	logic                     slot_free;

	function automatic logic qual(input logic [PB-1:0] v, input logic [1:0] pm);
		logic q;
		unique case (pm)
			bm3_pkg::PAR_EVEN: q = !v[0];
			bm3_pkg::PAR_ODD:  q = v[0];
			default:           q = 1'b1;
		endcase
		return q;
	endfunction

	// Sum and count of the qualifying samples of one column.
	function automatic bm3_pkg::acc_t col_acc(input logic [PB-1:0] t, input logic [PB-1:0] m,
			input logic [PB-1:0] b, input logic t_ok, input logic b_ok, input logic [1:0] pm);
		bm3_pkg::acc_t r;
		r.sum = '0;
		r.cnt = '0;
		if (t_ok && qual(t, pm)) begin
			r.sum = r.sum + SW'(t);
			r.cnt = r.cnt + NW'(1);
		end
		if (qual(m, pm)) begin
			r.sum = r.sum + SW'(m);
			r.cnt = r.cnt + NW'(1);
		end
		if (b_ok && qual(b, pm)) begin
			r.sum = r.sum + SW'(b);
			r.cnt = r.cnt + NW'(1);
		end
		return r;
	endfunction

	function automatic bm3_pkg::acc_t acc_add(input bm3_pkg::acc_t a, input bm3_pkg::acc_t b);
		bm3_pkg::acc_t r;
		r.sum = a.sum + b.sum;
		r.cnt = a.cnt + b.cnt;
		return r;
	endfunction

	// Effective width: zero acts as one, anything above the buffer depth as the depth.
	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = WW'(1);
		end else if (WW'(frame_width_q) > WW'(bm3_pkg::MAX_WIDTH)) begin
			eff_w = WW'(bm3_pkg::MAX_WIDTH);
		end else begin
			eff_w = WW'(frame_width_q);
		end
	end

	assign s_tready = (state_q == S_IDLE) && !cfg_we;
	assign accept   = s_tvalid && s_tready;

	// A pixel arriving during an unfinished flush starts a new frame.
	assign restart  = (flush_q != '0);
	assign pix_c    = (restart || (WW'(col_q) >= eff_w)) ? '0 : col_q;
	assign pix_rows = restart ? 2'd0 : rows_q;
	assign pix_last = (WW'(pix_c) + WW'(1) == eff_w);

	// A flush counts only at a row boundary after at least one complete row.
	assign flush_ok = (col_q == '0) && (rows_q != 2'd0);
	assign fl_k     = (WW'(flush_q) >= eff_w) ? '0 : flush_q;
	assign fl_ok0   = (fl_k != '0);
	assign fl_ok2   = (WW'(fl_k) + WW'(1) < eff_w);
	assign fl_last  = (WW'(fl_k) + WW'(1) == eff_w);

	// Line buffer reads: one column on acceptance, then the next two columns of a flush.
	// Writes happen only in S_PRD, so a read never meets a write to the same entry.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && s_tuser == bm3_pkg::KIND_PIXEL) begin
					ram_re    = 1'b1;
					ram_raddr = pix_c;
				end else if (accept && flush_ok) begin
					ram_re    = 1'b1;
					ram_raddr = fl_ok0 ? fl_k - CW'(1) : '0;
				end
			end
			S_F0: begin
				ram_re    = 1'b1;
				ram_raddr = addr_q;
			end
			S_F1: begin
				ram_re    = 1'b1;
				ram_raddr = ok2_q ? addr_q + CW'(1) : '0;
			end
			default: begin
				ram_re    = 1'b0;
				ram_raddr = '0;
			end
		endcase
	end

	assign ram_we   = (state_q == S_PRD);
	assign rd_older = ram_rdata[LW-1:PB];
	assign rd_newer = ram_rdata[PB-1:0];

	bm3_ram #(
		.WIDTH (LW),
		.DEPTH (bm3_pkg::MAX_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata ({rd_newer, pix_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Column sums. For a pixel the bottom row is the incoming sample; a flush has none.
	assign acc_cur = col_acc(rd_older, rd_newer, pix_q, top_ok_q, 1'b1, parity_q);
	assign acc_w1  = col_acc(win_q[3], win_q[4], win_q[5], top_ok_q, 1'b1, parity_q);
	assign acc_w0  = col_acc(win_q[0], win_q[1], win_q[2], top_ok_q, 1'b1, parity_q);
	assign acc_fl  = col_acc(rd_older, rd_newer, '0, top_ok_q, 1'b0, parity_q);

	// First result centres on the last column, second closes the row at its last column.
	assign sum1 = acc_add(acc_add(col0_ok_q ? acc_w0 : '0, acc_w1), acc_cur);
	assign sum2 = acc_add(col1_ok_q ? acc_w1 : '0, acc_cur);

	// Division by the count through the reciprocal table; the output register follows.
	assign prod = PW'(res_a_q.sum) * PW'(bm3_pkg::recip(res_a_q.cnt));
	assign slot_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			frame_width_q <= bm3_pkg::FRAME_WIDTH_RESET;
			parity_q      <= bm3_pkg::PAR_ALL;
			col_q         <= '0;
			rows_q        <= 2'd0;
			flush_q       <= '0;
			pend_b_q      <= 1'b0;
			m_valid_q     <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			// The output register is loaded in S_EMIT once it is free, and it
			// empties when the sink takes the result.
			m_valid_q <= (state_q == S_EMIT) || (m_valid_q && !m_tready);
			unique case (state_q)
				S_IDLE: begin
					if (accept && s_tuser == bm3_pkg::KIND_PIXEL) begin
						pix_q     <= s_tdata[PB-1:0];
						addr_q    <= pix_c;
						top_ok_q  <= (pix_rows >= 2'd2);
						has1_q    <= (pix_rows != 2'd0) && (pix_c != '0);
						has2_q    <= (pix_rows != 2'd0) && pix_last;
						col0_ok_q <= (pix_c >= CW'(2));
						col1_ok_q <= (pix_c != '0);
						flush_q   <= '0;
						if (pix_last) begin
							col_q  <= '0;
							rows_q <= (pix_rows < 2'd2) ? pix_rows + 2'd1 : pix_rows;
						end else begin
							col_q  <= pix_c + CW'(1);
							rows_q <= pix_rows;
						end
						state_q <= S_PRD;
					end else if (accept && flush_ok) begin
						addr_q   <= fl_k;
						top_ok_q <= (rows_q >= 2'd2);
						ok2_q    <= fl_ok2;
						last_q   <= fl_last;
						if (fl_last) begin
							col_q   <= '0;
							rows_q  <= 2'd0;
							flush_q <= '0;
						end else begin
							flush_q <= fl_k + CW'(1);
						end
						state_q <= S_F0;
					end
				end
				S_PRD: begin
					// Shift the window and stage the results of this pixel.
					for (int i = 0; i < 3; i++) begin
						win_q[i] <= win_q[i + 3];
					end
					win_q[3] <= rd_older;
					win_q[4] <= rd_newer;
					win_q[5] <= pix_q;
					res_a_q  <= has1_q ? sum1 : sum2;
					res_b_q  <= sum2;
					end_a_q  <= 1'b0;
					pend_b_q <= has1_q && has2_q;
					state_q  <= (has1_q || has2_q) ? S_EMIT : S_IDLE;
				end
				S_F0: begin
					res_a_q <= (addr_q != '0) ? acc_fl : '0;
					state_q <= S_F1;
				end
				S_F1: begin
					res_a_q <= acc_add(res_a_q, acc_fl);
					state_q <= S_F2;
				end
				S_F2: begin
					res_a_q  <= acc_add(res_a_q, ok2_q ? acc_fl : '0);
					end_a_q  <= last_q;
					pend_b_q <= 1'b0;
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						m_mean_q  <= prod[bm3_pkg::RECIP_SHIFT +: MW];
						m_cnt_q   <= res_a_q.cnt;
						m_last_q  <= end_a_q;
						if (pend_b_q) begin
							res_a_q  <= res_b_q;
							end_a_q  <= 1'b0;
							pend_b_q <= 1'b0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A register write restarts the frame.
			if (cfg_we) begin
				if (cfg_index == bm3_pkg::REG_FRAME_WIDTH) begin
					frame_width_q <= cfg_data;
				end else begin
					parity_q <= cfg_data[1:0];
				end
				col_q   <= '0;
				rows_q  <= 2'd0;
				flush_q <= '0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, m_cnt_q, m_mean_q};
	assign m_tlast  = m_last_q;

	// The line buffer is never read and written in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("line buffer read and write in the same cycle");

	// A second result is only pending while results are being delivered.
	a_pend_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pend_b_q |-> (state_q == S_EMIT))
		else $error("second result pending outside delivery");

	// A result that is being delivered never counts more than nine neighbours.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (res_a_q.cnt <= NW'(9)))
		else $error("neighbour count out of range");

	// Delivery into a free output register shows a valid result on the next cycle.
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && slot_free) |=> m_valid_q)
		else $error("result not loaded into output register");

	// The completed-row count saturates at two.
	a_rows_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q != 2'd3)
		else $error("row count beyond saturation");

endmodule

// File: dv/box_mean_3x3_filter_core_tb.sv
// Self-checking testbench for box_mean_3x3_filter_core: random and directed pixel streams
// against a cycle-free predictor of the 3x3 box mean, with random stalls on both streams.
// Depends on bm3_pkg and the core RTL; needs no files or arguments.
module box_mean_3x3_filter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FW_W      = bm3_pkg::FW_W;
	localparam int MAX_WIDTH = bm3_pkg::MAX_WIDTH;

	// One output pixel as the core should deliver it.
	typedef struct packed {
		logic [15:0] mean;
		logic [3:0]  count;
		logic        frame_end;
	} box_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [FW_W-1:0]     cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [15:0]         s_tdata;   // [15:0] pixel_value
	logic                s_tuser;   // [0] kind
	logic                m_tvalid;
	logic                m_tready;
	logic [23:0]         m_tdata;   // [15:0] mean_value, [19:16] neighbour_count
	logic                m_tlast;   // frame_end

	box_mean_3x3_filter_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Output pixels predicted but not yet seen on the output stream, oldest first.
	box_result_t expected_means[$];
	int unsigned mismatches;
	int unsigned fed_items;   // accepted requests that the core does not simply drop
	bit          tx_gaps;     // sender inserts idle cycles between requests
	bit          rx_stalls;   // receiver drops m_tready at random

	// Predictor state: configuration, the two stored rows, the 3x2 window of the two
	// previous columns (top, middle, bottom of the older column, then of the newer one),
	// and the frame sequencing counters.
	logic [FW_W-1:0] width_reg;
	logic [1:0]      parity_reg;
	logic [15:0]     older_row [0:MAX_WIDTH-1];
	logic [15:0]     newer_row [0:MAX_WIDTH-1];
	logic [15:0]     win [0:5];
	int unsigned     col_idx;
	int unsigned     rows_done;
	int unsigned     flush_pos;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Generous bound: several times the slowest legal run with every stall at its longest.
	initial begin
		#30_000_000;
		$display("box_mean_3x3_filter_core_tb failed");
		$finish;
	end

	function automatic void restart_frame();
		col_idx = 0;
		rows_done = 0;
		flush_pos = 0;
	endfunction

	function automatic void clear_model();
		width_reg = bm3_pkg::FRAME_WIDTH_RESET;
		parity_reg = bm3_pkg::PAR_ALL;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			older_row[i] = '0;
			newer_row[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			win[i] = '0;
		restart_frame();
	endfunction

	// A width of zero behaves as one; anything above the line buffer is clamped to it.
	function automatic int unsigned active_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return 32'(width_reg);
	endfunction

	// The unused parity code falls through to "all neighbours".
	function automatic bit passes_parity(logic [15:0] v);
		case (parity_reg)
			bm3_pkg::PAR_EVEN: return !v[0];
			bm3_pkg::PAR_ODD:  return v[0];
			default:           return 1'b1;
		endcase
	endfunction

	function automatic void add_column(input logic [15:0] top, mid, bot, input bit col_ok,
			input bit top_ok, input bit bot_ok, inout int unsigned sum, inout int unsigned cnt);
		if (!col_ok)
			return;
		if (top_ok && passes_parity(top)) begin
			sum += top;
			cnt++;
		end
		if (passes_parity(mid)) begin
			sum += mid;
			cnt++;
		end
		if (bot_ok && passes_parity(bot)) begin
			sum += bot;
			cnt++;
		end
	endfunction

	function automatic void push_result(int unsigned sum, int unsigned cnt, bit at_end);
		box_result_t r;
		r.mean = (cnt != 0) ? 16'(sum / cnt) : 16'd0;
		r.count = 4'(cnt);
		r.frame_end = at_end;
		expected_means.insert(expected_means.size(), r);
	endfunction

	// Advances the predictor by one accepted request and queues the output pixels it
	// causes. Returns 0 for a flush that the core drops without any effect.
	function automatic bit predict_request(logic kind, logic [15:0] pix);
		int unsigned w, c, k, j, sum, cnt;
		logic [15:0] cur [0:2];
		bit          top_ok, ok;
		w = active_width();
		if (kind == bm3_pkg::KIND_PIXEL) begin
			// A pixel arriving in the middle of a flush abandons it and opens a new frame.
			if (flush_pos != 0)
				restart_frame();
			c = col_idx;
			if (c >= w)
				c = 0;
			cur[0] = older_row[c];
			cur[1] = newer_row[c];
			cur[2] = pix;
			top_ok = rows_done >= 2;
			// Row r produces row r-1: the column to the left, and at the right edge
			// also the last column of the row above.
			if (rows_done >= 1) begin
				if (c >= 1) begin
					sum = 0;
					cnt = 0;
					add_column(win[0], win[1], win[2], c >= 2, top_ok, 1'b1, sum, cnt);
					add_column(win[3], win[4], win[5], 1'b1, top_ok, 1'b1, sum, cnt);
					add_column(cur[0], cur[1], cur[2], 1'b1, top_ok, 1'b1, sum, cnt);
					push_result(sum, cnt, 1'b0);
				end
				if (c + 1 == w) begin
					sum = 0;
					cnt = 0;
					add_column(win[3], win[4], win[5], c >= 1, top_ok, 1'b1, sum, cnt);
					add_column(cur[0], cur[1], cur[2], 1'b1, top_ok, 1'b1, sum, cnt);
					push_result(sum, cnt, 1'b0);
				end
			end
			for (int i = 0; i < 3; i++) begin
				win[i] = win[i + 3];
				win[i + 3] = cur[i];
			end
			older_row[c] = cur[1];
			newer_row[c] = cur[2];
			if (c + 1 >= w) begin
				col_idx = 0;
				if (rows_done < 2)
					rows_done++;
			end else begin
				col_idx = c + 1;
			end
			return 1'b1;
		end
		// Flush ticks only count at a row boundary once a full row has been stored.
		if (col_idx != 0 || rows_done == 0)
			return 1'b0;
		k = flush_pos;
		if (k >= w)
			k = 0;
		sum = 0;
		cnt = 0;
		top_ok = rows_done >= 2;
		for (int d = -1; d <= 1; d++) begin
			if (d < 0) begin
				ok = k >= 1;
				j = ok ? k - 1 : 0;
			end else if (d > 0) begin
				ok = k + 1 < w;
				j = ok ? k + 1 : 0;
			end else begin
				ok = 1'b1;
				j = k;
			end
			add_column(older_row[j], newer_row[j], 16'd0, ok, top_ok, 1'b0, sum, cnt);
		end
		push_result(sum, cnt, k + 1 == w);
		if (k + 1 >= w)
			restart_frame();
		else
			flush_pos = k + 1;
		return 1'b1;
	endfunction

	// Mostly no pause, often a short one, now and then a long one.
	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Pixel values lean toward the range ends so that the sums reach their extremes.
	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(0, 3));
			3:       return 16'hFFFF - 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		$display("[%0t] output mismatch: %s", $time, what);
	endtask

	// Called at a falling edge; returns at a falling edge with s_tvalid possibly still
	// high, so that a following request can go out back to back.
	task automatic send_request(logic kind, logic [15:0] pix);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= pix;
		do
			@(posedge clk);
		while (!s_tready);
		fed_items += predict_request(kind, pix);
		@(negedge clk);
		gap = tx_gaps ? pick_pause() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_pixel(logic [15:0] pix);
		send_request(bm3_pkg::KIND_PIXEL, pix);
	endtask

	// The pixel field of a flush is don't-care, so it carries noise.
	task automatic send_flush();
		send_request(bm3_pkg::KIND_FLUSH, 16'($urandom));
	endtask

	// Drains the output and then waits out a dropped flush that may still be in flight.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (expected_means.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// Every write restarts the frame in the core as well.
	task automatic write_register(logic idx, logic [FW_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == bm3_pkg::REG_FRAME_WIDTH)
			width_reg = value;
		else
			parity_reg = value[1:0];
		restart_frame();
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Reset configuration: a flush with nothing stored and a partial first row must
	// both stay silent.
	task automatic test_reset_defaults();
		send_flush();
		repeat (3) send_pixel(pick_pixel());
	endtask

	task automatic test_directed_cases();
		settle_block();
		write_register(bm3_pkg::REG_FRAME_WIDTH, 11'd3);
		write_register(bm3_pkg::REG_PARITY_MODE, 11'(bm3_pkg::PAR_ALL));
		send_flush();                      // dropped: no row stored yet
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'h8001);
		send_flush();                      // dropped: arrives in the middle of a row
		send_pixel(16'hFFFF);
		send_pixel(16'h7FFE);
		send_pixel(16'hFFFF);
		send_pixel(16'h0001);
		send_pixel(16'hFFFE);
		send_flush();
		send_pixel(16'h1234);              // abandons the flush, first pixel of a new frame
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		repeat (3) send_flush();           // single-row frame, last tick ends the frame
		settle_block();
		// Width zero runs as a one-pixel row; the spare parity code means all neighbours.
		write_register(bm3_pkg::REG_FRAME_WIDTH, 11'd0);
		write_register(bm3_pkg::REG_PARITY_MODE, 11'h7FF);
		send_pixel(16'hFFFF);
		send_pixel(16'h0001);
		send_flush();
		settle_block();
		write_register(bm3_pkg::REG_FRAME_WIDTH, 11'd2);
		write_register(bm3_pkg::REG_PARITY_MODE, 11'(bm3_pkg::PAR_ODD));
		send_pixel(16'h0002);
		send_pixel(16'h0003);
		send_pixel(16'hFFFE);
		send_pixel(16'hFFFF);
		send_flush();
		send_flush();
	endtask

	// Oversized width clamps to the full line buffer: one full row, after which the
	// first flush ticks are accepted only if the row wrapped at the buffer depth.
	task automatic test_widest_frame();
		settle_block();
		tx_gaps = 1'b0;
		rx_stalls = 1'b1;
		write_register(bm3_pkg::REG_FRAME_WIDTH, 11'h7FF);
		write_register(bm3_pkg::REG_PARITY_MODE, 11'(bm3_pkg::PAR_EVEN));
		repeat (MAX_WIDTH) send_pixel(pick_pixel());
		repeat (2) send_flush();
	endtask

	// Phases of random small widths and parity settings. Most frames are complete
	// rows followed by a full flush; the rest cut the flush short, scatter flushes
	// inside rows, or are plain noise.
	task automatic test_random_frames();
		int unsigned start_count, w, rows, r;
		logic [FW_W-1:0] width_val;
		start_count = fed_items;
		while (fed_items - start_count < 150) begin
			settle_block();
			tx_gaps = $urandom_range(0, 3) != 0;
			rx_stalls = $urandom_range(0, 3) != 0;
			r = $urandom_range(0, 99);
			if (r < 4)
				width_val = '0;
			else if (r < 70)
				width_val = FW_W'($urandom_range(1, 6));
			else
				width_val = FW_W'($urandom_range(7, 24));
			w = (width_val == 0) ? 1 : width_val;
			write_register(bm3_pkg::REG_FRAME_WIDTH, width_val);
			write_register(bm3_pkg::REG_PARITY_MODE, FW_W'($urandom));
			repeat ($urandom_range(1, 3)) begin
				rows = $urandom_range(1, 4);
				r = $urandom_range(0, 9);
				if (r < 7) begin
					repeat (rows * w) send_pixel(pick_pixel());
					repeat (w) send_flush();
				end else if (r == 7) begin
					repeat (rows * w) send_pixel(pick_pixel());
					repeat ($urandom_range(1, w)) send_flush();
				end else if (r == 8) begin
					repeat (rows * w + w) begin
						if ($urandom_range(0, 3) == 0)
							send_flush();
						else
							send_pixel(pick_pixel());
					end
				end else begin
					repeat (rows * w) begin
						if ($urandom_range(0, 6) == 0)
							send_flush();
						send_pixel(pick_pixel());
					end
					repeat (w) send_flush();
					repeat ($urandom_range(1, 3)) send_flush();
				end
			end
		end
	endtask

	// Receiver: ready in runs, with random stalls in between when enabled.
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			stall = rx_stalls ? pick_pause() : 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	// Every accepted output pixel is compared with the oldest prediction.
	always @(posedge clk) begin
		box_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_means.size() == 0) begin
				report_mismatch($sformatf("unexpected output mean %0d count %0d end %0b",
					m_tdata[15:0], m_tdata[19:16], m_tlast));
			end else begin
				want = expected_means.pop_front();
				if (m_tdata[15:0] !== want.mean)
					report_mismatch($sformatf("mean %0h, want %0h", m_tdata[15:0], want.mean));
				if (m_tdata[19:16] !== want.count)
					report_mismatch($sformatf("count %0d, want %0d", m_tdata[19:16],
						want.count));
				if (m_tlast !== want.frame_end)
					report_mismatch($sformatf("frame end %0b, want %0b", m_tlast,
						want.frame_end));
				if (m_tdata[23:20] !== 4'h0)
					report_mismatch($sformatf("padding bits %0h", m_tdata[23:20]));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bm3_pkg::REG_FRAME_WIDTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = bm3_pkg::KIND_PIXEL;
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		mismatches = 0;
		fed_items = 0;
		clear_model();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_directed_cases();
		test_widest_frame();
		test_random_frames();
		settle_block();
		if (mismatches == 0)
			$display("box_mean_3x3_filter_core_tb passed");
		else
			$display("box_mean_3x3_filter_core_tb failed");
		$finish;
	end

endmodule

// File: box_mean_3x3_filter_core.f
hw/rtl/bm3_pkg.sv
hw/rtl/bm3_ram.sv
hw/rtl/box_mean_3x3_filter_core.sv
dv/box_mean_3x3_filter_core_tb.sv
